>>> hw/rtl/bdte_pkg.sv
// Package: shared types, calendar constants and decode helpers for the BCD date to epoch block.
`timescale 1ns / 1ps

package bdte_pkg;

    // Field widths
    localparam int unsigned BcdW   = 8;
    localparam int unsigned EpochW = 32;
    localparam int unsigned DecW   = 8;   // decoded byte, 0..165
    localparam int unsigned DaysW  = 10;  // leap days + month days + day of month

    // Time constants
    localparam logic [EpochW-1:0] SecsPerDay  = 32'd86400;
    localparam logic [EpochW-1:0] SecsPerHour = 32'd3600;
    localparam logic [EpochW-1:0] SecsPerMin  = 32'd60;
    // Seconds in one common year (365 days)
    localparam logic [EpochW-1:0] SecsPerYear = 32'd31536000;
    // 1970..1999 as common years: 30 * 365 days
    localparam logic [EpochW-1:0] BaseSecs    = 32'd946080000;
    // Leap years in 1970..1999
    localparam logic [6:0]        BaseLeaps   = 7'd7;
    // Two-digit year that lands on 2100 (not a leap year)
    localparam logic [DecW-1:0]   YearCentury = 8'd100;

    // Month codes used in range checks
    localparam logic [DecW-1:0]   MonJan = 8'd1;
    localparam logic [DecW-1:0]   MonMar = 8'd3;
    localparam logic [DecW-1:0]   MonDec = 8'd12;

    // One raw item: six BCD bytes
    typedef struct packed {
        logic [BcdW-1:0] second_bcd;
        logic [BcdW-1:0] minute_bcd;
        logic [BcdW-1:0] hour_bcd;
        logic [BcdW-1:0] day_bcd;
        logic [BcdW-1:0] month_bcd;
        logic [BcdW-1:0] year_bcd;
    } t_bcd_item;

    // High nibble times ten plus low nibble, no validity check
    function automatic logic [DecW-1:0] bcd_decode(input logic [BcdW-1:0] b);
        logic [DecW-1:0] hi;
        logic [DecW-1:0] lo;
        hi = {4'd0, b[7:4]};
        lo = {4'd0, b[3:0]};
        return (hi << 3) + (hi << 1) + lo;
    endfunction

    // Days before the first of the month, common year; month 1..12
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/bdte_if.sv
// Interfaces: input date channel and output epoch channel, valid/ready handshake.
`timescale 1ns / 1ps

interface bdte_in_if;
    logic                         valid;
    logic                         ready;
    logic [bdte_pkg::BcdW-1:0]    second_bcd;
    logic [bdte_pkg::BcdW-1:0]    minute_bcd;
    logic [bdte_pkg::BcdW-1:0]    hour_bcd;
    logic [bdte_pkg::BcdW-1:0]    day_bcd;
    logic [bdte_pkg::BcdW-1:0]    month_bcd;
    logic [bdte_pkg::BcdW-1:0]    year_bcd;

    modport source (
        output valid, second_bcd, minute_bcd, hour_bcd, day_bcd, month_bcd, year_bcd,
        input  ready
    );
    modport sink (
        input  valid, second_bcd, minute_bcd, hour_bcd, day_bcd, month_bcd, year_bcd,
        output ready
    );
endinterface

interface bdte_out_if;
    logic                          valid;
    logic                          ready;
    logic [bdte_pkg::EpochW-1:0]   epoch_seconds;

    modport source (output valid, epoch_seconds, input ready);
    modport sink   (input  valid, epoch_seconds, output ready);
endinterface

>>> hw/rtl/bdte_calc.sv
// Combinational date to epoch seconds conversion for one registered item.
`timescale 1ns / 1ps

module bdte_calc (
    input  bdte_pkg::t_bcd_item              i_item,
    output logic [bdte_pkg::EpochW-1:0]      o_epoch_seconds
);

    logic [bdte_pkg::DecW-1:0]  sec;
    logic [bdte_pkg::DecW-1:0]  min;
    logic [bdte_pkg::DecW-1:0]  hour;
    logic [bdte_pkg::DecW-1:0]  day;
    logic [bdte_pkg::DecW-1:0]  mon;
    logic [bdte_pkg::DecW-1:0]  yv;
    logic [8:0]                 yv_up;
    logic [6:0]                 leaps;
    logic                       cur_leap;
    logic                       mon_ok;
    logic [8:0]                 mdays;
    logic                       leap_adj;
    logic [bdte_pkg::DaysW-1:0] days;
    logic [31:0]                year_secs;
    logic [31:0]                day_secs;
    logic [31:0]                tod_secs;

    // Decode all six bytes
    assign sec  = bdte_pkg::bcd_decode(i_item.second_bcd);
    assign min  = bdte_pkg::bcd_decode(i_item.minute_bcd);
    assign hour = bdte_pkg::bcd_decode(i_item.hour_bcd);
    assign day  = bdte_pkg::bcd_decode(i_item.day_bcd);
    assign mon  = bdte_pkg::bcd_decode(i_item.month_bcd);
    assign yv   = bdte_pkg::bcd_decode(i_item.year_bcd);

    // Leap years in 1970..(2000+yv-1): 2000, 2004, ... minus 2100 once passed
    assign yv_up = {1'b0, yv} + 9'd3;
    assign leaps = bdte_pkg::BaseLeaps + yv_up[8:2]
                 - {6'd0, (yv > bdte_pkg::YearCentury)};

    // Current year leap: multiple of four, except 2100
    assign cur_leap = (yv[1:0] == 2'b00) && (yv != bdte_pkg::YearCentury);

    // Earlier months of the current year
    assign mon_ok   = (mon >= bdte_pkg::MonJan) && (mon <= bdte_pkg::MonDec);
    assign mdays    = mon_ok ? bdte_pkg::days_before_month(mon[3:0]) : 9'd0;
    assign leap_adj = mon_ok && (mon >= bdte_pkg::MonMar) && cur_leap;

    // Days beyond the whole common years; leaps >= 7 keeps day zero from underflowing
    assign days = {3'd0, leaps} + {1'b0, mdays} + {9'd0, leap_adj}
                + {2'd0, day} - 10'd1;

    // Independent constant products, summed modulo 2^32
    assign year_secs = 32'({24'd0, yv} * bdte_pkg::SecsPerYear);
    assign day_secs  = 32'({22'd0, days} * bdte_pkg::SecsPerDay);
    assign tod_secs  = 32'({24'd0, hour} * bdte_pkg::SecsPerHour)
                     + 32'({24'd0, min} * bdte_pkg::SecsPerMin)
                     + {24'd0, sec};

    assign o_epoch_seconds = bdte_pkg::BaseSecs + year_secs + day_secs + tod_secs;

endmodule

>>> hw/rtl/bcd_datetime_to_epoch_seconds_unit.sv
// Top level: BCD date/time item to seconds since 1970-01-01, two-register pipeline.
//
//  Channel   Dir  Handshake          Payload
//  i_item    in   valid/ready        second/minute/hour/day/month/year_bcd, 8 bits each
//  o_result  out  valid/ready        epoch_seconds, 32 bits
//
// One item per cycle sustained while o_result.ready is high; an accepted item enters the
// input register, and o_result.valid rises when it moves into the result register.
// The input register feeds one pass of constant multiplies and a sum into the result register.
// Reset (i_rst_n low, synchronous) empties both registers.
// A stalled output holds its item; input ready drops only when both registers are full
// and o_result.ready is low.
`timescale 1ns / 1ps

module bcd_datetime_to_epoch_seconds_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bdte_in_if.sink              i_item,
    bdte_out_if.source           o_result
);

    bdte_pkg::t_bcd_item                r_in;
    logic                               r_in_valid;
    logic [bdte_pkg::EpochW-1:0]        r_epoch;
    logic                               r_out_valid;
    logic [bdte_pkg::EpochW-1:0]        n_epoch;
    logic                               out_adv;
    logic                               in_adv;

    // Pipeline flow control
    assign out_adv      = !r_out_valid || o_result.ready;
    assign in_adv       = !r_in_valid || out_adv;
    assign i_item.ready = in_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_item.valid;
        end
        if (in_adv && i_item.valid) begin
            r_in.second_bcd <= i_item.second_bcd;
            r_in.minute_bcd <= i_item.minute_bcd;
            r_in.hour_bcd   <= i_item.hour_bcd;
            r_in.day_bcd    <= i_item.day_bcd;
            r_in.month_bcd  <= i_item.month_bcd;
            r_in.year_bcd   <= i_item.year_bcd;
        end
    end

    // Conversion
    bdte_calc u_calc (
        .i_item          (r_in),
        .o_epoch_seconds (n_epoch)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
        if (out_adv && r_in_valid) begin
            r_epoch <= n_epoch;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.epoch_seconds = r_epoch;

    // Checks
    a_in_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> r_in_valid)
        else $error("accepted item did not reach the input register");

    a_in_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_adv) |=> o_result.valid)
        else $error("registered item did not reach the result register");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_result.valid && !r_in_valid))
        else $error("pipeline not empty after reset");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_adv) |=> (r_in_valid && $stable(r_in)))
        else $error("stalled input register lost its item");

endmodule
